/* rtl/tmrlf_pkg.sv */
`default_nettype none

package tmrlf_pkg;

    localparam int RELAY_COUNT_DEF = 4;
    localparam int FADE_COUNT_DEF  = 2;

    localparam int RELAY_MAX = 8;
    localparam int FADE_MAX  = 8;

    // field widths
    localparam int TIME_W   = 32;
    localparam int TEMP_W   = 10;
    localparam int IVAL_W   = 16;
    localparam int LEVEL_W  = 8;
    localparam int RBITS_W  = 4;
    localparam int STEP_W   = 4;
    localparam int RTIME_W  = 10;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    // config port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_MODE_THRESHOLD  = 1'b0;
    localparam logic REG_SAMPLE_INTERVAL = 1'b1;

    localparam logic [TEMP_W-1:0] THRESHOLD_RST = 10'd512;
    localparam logic [IVAL_W-1:0] INTERVAL_RST  = 16'd1000;

    // relay timing
    localparam logic [RTIME_W-1:0] COOL_ON_BASE  = 10'd510;
    localparam logic [RTIME_W-1:0] COOL_OFF_BASE = 10'd520;
    localparam logic [RTIME_W-1:0] COOL_STRIDE   = 10'd20;
    localparam logic [RTIME_W-1:0] WARM_TOGGLE   = 10'd200;

    // fade timing
    localparam logic [STEP_W-1:0] FADE_FAST      = 4'd0;
    localparam logic [STEP_W-1:0] FADE_SLOW      = 4'd4;
    localparam logic [STEP_W-1:0] FADE_WARM_EVEN = 4'd10;
    localparam logic [STEP_W-1:0] FADE_WARM_ODD  = 4'd11;

    localparam logic MODE_COOL = 1'b0;
    localparam logic MODE_WARM = 1'b1;

    localparam logic [LEVEL_W-1:0] LEVEL_TOP     = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_NEAR_TOP = 8'd254;

    function automatic logic [RTIME_W-1:0] relay_on_ms(input logic mode, input logic [2:0] idx);
        logic [RTIME_W-1:0] span;
        span = COOL_STRIDE * RTIME_W'(idx);
        return (mode == MODE_WARM) ? WARM_TOGGLE : COOL_ON_BASE + span;
    endfunction

    function automatic logic [RTIME_W-1:0] relay_off_ms(input logic mode, input logic [2:0] idx);
        logic [RTIME_W-1:0] span;
        span = COOL_STRIDE * RTIME_W'(idx);
        return (mode == MODE_WARM) ? WARM_TOGGLE : COOL_OFF_BASE + span;
    endfunction

    // even channels rise fast and fall slow in cool mode, odd ones the reverse
    function automatic logic [STEP_W-1:0] fade_step_ms(input logic mode, input logic falling,
                                                      input logic odd);
        logic [STEP_W-1:0] ms;
        if (mode == MODE_WARM) begin
            ms = odd ? FADE_WARM_ODD : FADE_WARM_EVEN;
        end else begin
            ms = (falling ^ odd) ? FADE_SLOW : FADE_FAST;
        end
        return ms;
    endfunction

endpackage

`default_nettype wire

/* rtl/thermal_mode_relay_blink_and_led_fade_core.sv */
`default_nettype none

// thermal mode relay blinker and led fader. each input item carries a
// millisecond time stamp and a 10-bit temperature sample; each one yields
// exactly one result item with the relay states, two fade levels, the mode
// and a restart flag. the block takes one item per clock while the result
// side is not stalled: an input register holds the item, a single pass of
// compare and add logic updates the mode, relay and fade state, and the
// result lands in an output register. while a finished result waits, one
// more item can be taken into the input register, after which s_tready
// stays low until the result is taken. configuration registers
// (mode_threshold at 0x0, sample_interval_ms at 0x4) are written through the
// apb port and should only change while no item is in flight.
module thermal_mode_relay_blink_and_led_fade_core #(
    parameter int RELAY_COUNT = tmrlf_pkg::RELAY_COUNT_DEF,
    parameter int FADE_COUNT  = tmrlf_pkg::FADE_COUNT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input item channel
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [31:0] now_ms, [41:32] raw_temperature, [47:42] zero
    input  wire logic [tmrlf_pkg::S_TDATA_W-1:0] s_tdata,
    // result item channel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [3:0] relay_bits, [11:4] led_a_level, [19:12] led_b_level,
    // [20] mode, [21] mode_changed, [23:22] zero
    output logic [tmrlf_pkg::M_TDATA_W-1:0]    m_tdata,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tmrlf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [tmrlf_pkg::PDATA_W-1:0] pwdata,
    output logic [tmrlf_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);
    import tmrlf_pkg::*;

    // ---------------- configuration ----------------
    logic [TEMP_W-1:0] threshold_reg;
    logic [IVAL_W-1:0] interval_reg;
    logic              cfg_write;
    logic              cfg_sel;

    assign pready    = 1'b1;
    assign cfg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RST;
            interval_reg  <= INTERVAL_RST;
        end else if (cfg_write) begin
            unique case (cfg_sel)
                REG_MODE_THRESHOLD:  threshold_reg <= pwdata[TEMP_W-1:0];
                REG_SAMPLE_INTERVAL: interval_reg  <= pwdata[IVAL_W-1:0];
                default:             threshold_reg <= threshold_reg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_MODE_THRESHOLD:  prdata = {{(PDATA_W-TEMP_W){1'b0}}, threshold_reg};
            REG_SAMPLE_INTERVAL: prdata = {{(PDATA_W-IVAL_W){1'b0}}, interval_reg};
            default:             prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    logic              in_valid_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic [TEMP_W-1:0] in_raw_reg;
    logic              out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic              advance;     // output register can take a new result
    logic              fire;        // item in the input register is processed now

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_now_reg <= s_tdata[TIME_W-1:0];
            in_raw_reg <= s_tdata[TIME_W+TEMP_W-1:TIME_W];
        end
    end

    // ---------------- mode decision ----------------
    logic              mode_reg;
    logic              mode_seen_reg;   // cleared by reset so the first item restarts
    logic [TIME_W-1:0] decision_mark_reg;
    logic [TIME_W-1:0] decision_el;
    logic              decide;
    logic              mode_next;
    logic              restart;

    assign decision_el = in_now_reg - decision_mark_reg;
    assign decide      = decision_el >= {{(TIME_W-IVAL_W){1'b0}}, interval_reg};
    assign mode_next   = decide ? (in_raw_reg >= threshold_reg) : mode_reg;
    assign restart     = !mode_seen_reg || (mode_next != mode_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_COOL;
            mode_seen_reg     <= 1'b0;
            decision_mark_reg <= '0;
        end else if (fire) begin
            mode_reg      <= mode_next;
            mode_seen_reg <= 1'b1;
            if (decide) begin
                decision_mark_reg <= in_now_reg;
            end
        end
    end

    // ---------------- relays ----------------
    logic [RELAY_COUNT-1:0] relay_on_reg;
    logic [RELAY_COUNT-1:0] relay_on_next;
    logic [TIME_W-1:0]      relay_mark_reg [RELAY_COUNT];

    for (genvar r = 0; r < RELAY_COUNT; r++) begin : g_relay
        logic              on_base;
        logic [TIME_W-1:0] mark_base;
        logic [TIME_W-1:0] el;
        logic [RTIME_W-1:0] limit;
        logic              toggle;

        // a restart forces the relay off and the mark to now before the test
        assign on_base   = restart ? 1'b0 : relay_on_reg[r];
        assign mark_base = restart ? in_now_reg : relay_mark_reg[r];
        assign el        = in_now_reg - mark_base;
        assign limit     = on_base ? relay_on_ms(mode_next, 3'(r))
                                   : relay_off_ms(mode_next, 3'(r));
        assign toggle    = el >= {{(TIME_W-RTIME_W){1'b0}}, limit};
        assign relay_on_next[r] = on_base ^ toggle;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                relay_on_reg[r]   <= 1'b0;
                relay_mark_reg[r] <= '0;
            end else if (fire) begin
                relay_on_reg[r]   <= relay_on_next[r];
                relay_mark_reg[r] <= toggle ? in_now_reg : mark_base;
            end
        end
    end

    // ---------------- fades ----------------
    logic [LEVEL_W-1:0] fade_level_reg   [FADE_COUNT];
    logic [LEVEL_W-1:0] fade_level_next  [FADE_COUNT];
    logic [FADE_COUNT-1:0] fade_falling_reg;
    logic [TIME_W-1:0]  fade_mark_reg    [FADE_COUNT];

    for (genvar f = 0; f < FADE_COUNT; f++) begin : g_fade
        logic [LEVEL_W-1:0] level_base;
        logic               falling_base;
        logic [TIME_W-1:0]  mark_base;
        logic [TIME_W-1:0]  el;
        logic [STEP_W-1:0]  step_ms;
        logic               step;
        logic               falling_next;

        assign level_base   = restart ? '0 : fade_level_reg[f];
        assign falling_base = restart ? 1'b0 : fade_falling_reg[f];
        assign mark_base    = restart ? in_now_reg : fade_mark_reg[f];
        assign el           = in_now_reg - mark_base;
        assign step_ms      = fade_step_ms(mode_next, falling_base, 1'((f % 2)));
        assign step         = el >= {{(TIME_W-STEP_W){1'b0}}, step_ms};

        // one step toward the current end, turning around at 0 and 255
        always_comb begin
            fade_level_next[f] = level_base;
            falling_next       = falling_base;
            if (step) begin
                if (falling_base) begin
                    if (level_base <= LEVEL_W'(1)) begin
                        fade_level_next[f] = '0;
                        falling_next       = 1'b0;
                    end else begin
                        fade_level_next[f] = level_base - LEVEL_W'(1);
                    end
                end else begin
                    if (level_base >= LEVEL_NEAR_TOP) begin
                        fade_level_next[f] = LEVEL_TOP;
                        falling_next       = 1'b1;
                    end else begin
                        fade_level_next[f] = level_base + LEVEL_W'(1);
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                fade_level_reg[f]   <= '0;
                fade_falling_reg[f] <= 1'b0;
                fade_mark_reg[f]    <= '0;
            end else if (fire) begin
                fade_level_reg[f]   <= fade_level_next[f];
                fade_falling_reg[f] <= falling_next;
                fade_mark_reg[f]    <= step ? in_now_reg : mark_base;
            end
        end
    end

    // ---------------- result ----------------
    logic [RBITS_W-1:0] relay_bits;
    logic [LEVEL_W-1:0] led_b_level;

    // only the first four relays are visible on the result
    for (genvar b = 0; b < RBITS_W; b++) begin : g_bits
        if (b < RELAY_COUNT) begin : g_on
            assign relay_bits[b] = relay_on_next[b];
        end else begin : g_off
            assign relay_bits[b] = 1'b0;
        end
    end

    if (FADE_COUNT > 1) begin : g_led_b
        assign led_b_level = fade_level_next[1];
    end else begin : g_no_led_b
        assign led_b_level = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {2'b00, restart, mode_next, led_b_level,
                             fade_level_next[0], relay_bits};
        end
    end

endmodule

`default_nettype wire

/* rtl/tmrlf_checker.sv */
`default_nettype none

module tmrlf_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [tmrlf_pkg::M_TDATA_W-1:0] m_tdata
);
    import tmrlf_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a restart leaves every relay off and the first fade at most one step up
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[21] |-> m_tdata[3:0] == 4'b0000 && m_tdata[11:4] <= 8'd1)
        else $error("restart result with relays on or fade advanced");

    // in warm mode no fade steps in the restart pass
    a_warm_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[21] && m_tdata[20] |-> m_tdata[11:4] == 8'd0
            && m_tdata[19:12] == 8'd0)
        else $error("warm restart with nonzero fade level");

    // padding bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:22] == 2'b00)
        else $error("result padding not zero");

endmodule

bind thermal_mode_relay_blink_and_led_fade_core tmrlf_checker u_tmrlf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/sv/tb_thermal_mode_relay_blink_and_led_fade_core.sv */
`timescale 1ns / 100ps

module tb_thermal_mode_relay_blink_and_led_fade_core;
    import tmrlf_pkg::*;

    localparam int NUM_RELAYS     = 4;
    localparam int NUM_FADES      = 2;
    localparam int DIRECTED_ITEMS = 20;

    // ------------------------------------------------------------------
    // expected-behavior model and result checker
    // ------------------------------------------------------------------
    class relay_fade_scoreboard;
        typedef struct {
            logic [3:0] relay_bits;
            logic [7:0] led_a_level;
            logic [7:0] led_b_level;
            logic       mode;
            logic       mode_changed;
        } indication_t;

        // configuration as the block holds it, reset values
        logic [9:0]  threshold = 10'd512;
        logic [15:0] interval  = 16'd1000;

        // mode decision state
        logic [31:0] decision_mark = '0;
        logic        cur_mode      = 1'b0;
        logic        mode_known    = 1'b0;
        logic        last_mode     = 1'b0;

        // relay and fade channel state
        logic [NUM_RELAYS-1:0] relay_on = '0;
        logic [31:0]           relay_mark [NUM_RELAYS] = '{default: '0};
        logic [7:0]            level      [NUM_FADES]  = '{default: '0};
        logic                  falling    [NUM_FADES]  = '{default: 1'b0};
        logic [31:0]           fade_mark  [NUM_FADES]  = '{default: '0};

        indication_t pending_indications [$];
        int          failures = 0;

        function int pending();
            return pending_indications.size();
        endfunction

        // one accepted input item: advance the state and queue what the block must send
        function void note_sample(input logic [31:0] now, input logic [9:0] raw);
            logic [31:0] elapsed;
            logic [31:0] on_ms;
            logic [31:0] off_ms;
            logic [31:0] step_ms;
            logic        restart;
            indication_t want;

            elapsed = now - decision_mark;
            if (elapsed >= {16'd0, interval}) begin
                cur_mode      = (raw < threshold) ? 1'b0 : 1'b1;
                decision_mark = now;
            end
            restart    = !mode_known || (cur_mode != last_mode);
            mode_known = 1'b1;
            last_mode  = cur_mode;

            for (int i = 0; i < NUM_RELAYS; i++) begin
                if (restart) begin
                    relay_on[i]   = 1'b0;
                    relay_mark[i] = now;
                end
                if (cur_mode == MODE_WARM) begin
                    on_ms  = 32'd200;
                    off_ms = 32'd200;
                end else begin
                    on_ms  = 32'd510 + 32'd20 * i;
                    off_ms = 32'd520 + 32'd20 * i;
                end
                elapsed = now - relay_mark[i];
                if (relay_on[i]) begin
                    if (elapsed >= on_ms) begin
                        relay_on[i]   = 1'b0;
                        relay_mark[i] = now;
                    end
                end else if (elapsed >= off_ms) begin
                    relay_on[i]   = 1'b1;
                    relay_mark[i] = now;
                end
            end

            for (int i = 0; i < NUM_FADES; i++) begin
                if (restart) begin
                    level[i]     = '0;
                    falling[i]   = 1'b0;
                    fade_mark[i] = now;
                end
                // cool: even rise at once, fall slow; odd the reverse
                if (cur_mode == MODE_WARM) begin
                    step_ms = (i % 2 == 1) ? 32'd11 : 32'd10;
                end else begin
                    step_ms = (falling[i] ^ (i % 2 == 1)) ? 32'd4 : 32'd0;
                end
                elapsed = now - fade_mark[i];
                if (elapsed >= step_ms) begin
                    fade_mark[i] = now;
                    if (falling[i]) begin
                        if (level[i] <= 8'd1) begin
                            level[i]   = 8'd0;
                            falling[i] = 1'b0;
                        end else begin
                            level[i] = level[i] - 8'd1;
                        end
                    end else begin
                        if (level[i] >= 8'd254) begin
                            level[i]   = 8'd255;
                            falling[i] = 1'b1;
                        end else begin
                            level[i] = level[i] + 8'd1;
                        end
                    end
                end
            end

            want.relay_bits   = relay_on[3:0];
            want.led_a_level  = level[0];
            want.led_b_level  = level[1];
            want.mode         = cur_mode;
            want.mode_changed = restart;
            pending_indications.push_back(want);
        endfunction

        function void compare_field(input string field, input logic [7:0] want,
                                    input logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                failures++;
            end
        endfunction

        // one accepted result item against the oldest expectation
        function void check_indication(input logic [M_TDATA_W-1:0] tdata);
            indication_t want;
            if (pending_indications.size() == 0) begin
                $error("result item 0x%06h arrived with nothing expected", tdata);
                failures++;
                return;
            end
            want = pending_indications.pop_front();
            compare_field("relay_bits", 8'(want.relay_bits), 8'(tdata[3:0]));
            compare_field("led_a_level", want.led_a_level, tdata[11:4]);
            compare_field("led_b_level", want.led_b_level, tdata[19:12]);
            compare_field("mode", 8'(want.mode), 8'(tdata[20]));
            compare_field("mode_changed", 8'(want.mode_changed), 8'(tdata[21]));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tready = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [M_TDATA_W-1:0] m_tdata;
    wire  [PDATA_W-1:0]   prdata;
    wire                  pready;

    relay_fade_scoreboard sb;

    // percent of cycles each side holds back
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // running millisecond clock for the random part
    logic [31:0] stamp_ms;

    // directed items: decision edges, threshold edges, relay and fade timing,
    // same-stamp repeats, the all-ones stamp and wrap-safe elapsed time
    logic [31:0] directed_now [DIRECTED_ITEMS] = '{
        32'd0, 32'd999, 32'd1000, 32'd1010, 32'd1200, 32'd1400, 32'd2000, 32'd2000,
        32'd2520, 32'd2560, 32'd2580, 32'd3000, 32'hFFFF_FFFF, 32'h0000_03E6,
        32'h0000_03E7, 32'h0000_03E7, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5559,
        32'h5555_555D
    };
    logic [9:0] directed_raw [DIRECTED_ITEMS] = '{
        10'd0, 10'd1023, 10'd1023, 10'd0, 10'd0, 10'd511, 10'd511, 10'd512,
        10'd512, 10'd0, 10'd1000, 10'd512, 10'd0, 10'd1023,
        10'd1023, 10'd1023, 10'd1023, 10'd0, 10'h2AA,
        10'h155
    };

    thermal_mode_relay_blink_and_led_fade_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        // [31:0] now_ms, [41:32] raw_temperature, [47:42] zero
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // [3:0] relay_bits, [11:4] led_a_level, [19:12] led_b_level,
        // [20] mode, [21] mode_changed, [23:22] zero
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // reset held low from time zero and released once
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // every accepted result item goes to the checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_indication(m_tdata);
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one item, with random gaps ahead of it, and note it once taken
    task automatic send_item(input logic [31:0] now, input logic [9:0] raw);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, raw, now};
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(now, raw);
    endtask

    // stop sending and let every expected result come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // apb write: setup cycle, then access until pready
    task automatic write_register(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MODE_THRESHOLD) begin
            sb.threshold = value[9:0];
        end else begin
            sb.interval = value[15:0];
        end
    endtask

    // random items in segments that lean cool or warm so channels run long
    // enough to toggle and ramp; the clock mostly creeps, sometimes leaps
    // or lands just below the wrap point
    task automatic run_phase(input int count, input int warm_pct, input int drain_at);
        int          seg_left;
        int          pick;
        logic        warm;
        logic [9:0]  raw;
        seg_left = 0;
        warm     = 1'b0;
        for (int k = 0; k < count; k++) begin
            if (k == drain_at) begin
                wait_drained();
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(60, 10);
                warm     = ($urandom_range(99) < warm_pct);
            end
            seg_left--;

            pick = $urandom_range(99);
            if (pick < 70) begin
                stamp_ms += $urandom_range(12, 0);
            end else if (pick < 88) begin
                stamp_ms += $urandom_range(260, 13);
            end else if (pick < 96) begin
                stamp_ms += $urandom_range(3000, 261);
            end else if (pick < 98) begin
                stamp_ms = $urandom();
            end else begin
                stamp_ms = 32'hFFFF_FFFF - $urandom_range(40, 0);
            end

            // a few samples are pure noise across the whole range
            if ($urandom_range(9) == 0) begin
                raw = 10'($urandom_range(1023, 0));
            end else if (warm || sb.threshold == 10'd0) begin
                raw = 10'($urandom_range(1023, sb.threshold));
            end else begin
                raw = 10'($urandom_range(sb.threshold - 1, 0));
            end
            send_item(stamp_ms, raw);
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        sb = new();
        do @(posedge aclk); while (!aresetn);

        // sender light gaps, receiver heavy stalls
        tx_idle_pct = 27;
        rx_idle_pct = 84;

        // directed items with the reset configuration
        for (int d = 0; d < DIRECTED_ITEMS; d++) begin
            send_item(directed_now[d], directed_raw[d]);
        end
        stamp_ms = directed_now[DIRECTED_ITEMS-1];

        // top threshold, longest interval: a long steady cool run lets the
        // fast fade climb to full scale and turn around; drain midway
        wait_drained();
        write_register(REG_MODE_THRESHOLD, 32'd1023);
        write_register(REG_SAMPLE_INTERVAL, 32'd65535);
        run_phase(280, 0, 140);

        // zero interval: every item decides, mode flips often
        wait_drained();
        tx_idle_pct = 84;
        rx_idle_pct = 27;
        write_register(REG_MODE_THRESHOLD, 32'd400);
        write_register(REG_SAMPLE_INTERVAL, 32'd0);
        run_phase(70, 50, -1);

        // zero threshold, shortest interval, back to back at full rate
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_register(REG_MODE_THRESHOLD, 32'd0);
        write_register(REG_SAMPLE_INTERVAL, 32'd1);
        run_phase(70, 50, -1);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (sb.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
